// ----- hdl/ffa_pkg.sv -----
`default_nettype none
package ffa_pkg;

   localparam int POOL_WORDS = 1024;
   localparam int WORD_BITS  = 11;
   localparam int ADDR_BITS  = 10;
   localparam int BYTE_BITS  = 13;
   localparam int NUM_BITS   = 12;

   typedef logic [WORD_BITS-1:0] word_type;

   // End-of-list mark, also the walk step limit.
   localparam word_type END_MARK = WORD_BITS'(POOL_WORDS);

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_A_RDCUR,
      S_A_SIZE,
      S_A_NEXT,
      S_A_FOUND,
      S_A_SPLIT,
      S_A_HDR,
      S_FA_RT,
      S_FA_TS,
      S_FA_AS,
      S_F_CHK,
      S_F_SIZE,
      S_F_NEXT,
      S_F_PS,
      S_F_TS,
      S_F_RT,
      S_F_RT2,
      S_F_RP,
      S_F_RC,
      S_FIN_OK,
      S_FIN_FAIL
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLEAR,
      OP_LOAD,
      OP_RD_CUR,
      OP_RD_T,
      OP_RD_PREV,
      OP_ALC_SIZE,
      OP_ALC_NEXT,
      OP_ALC_FOUND,
      OP_ALC_SPLIT,
      OP_ALC_HDR,
      OP_FA_TS,
      OP_FA_AS,
      OP_F_SIZE,
      OP_F_NEXT,
      OP_F_PS,
      OP_F_TS,
      OP_F_RT2,
      OP_F_RP,
      OP_F_RC,
      OP_OUT_OK,
      OP_OUT_FAIL
   } dp_op_type;

   typedef struct packed {
      logic clear_done;
      logic is_free;
      logic early_fail;
      logic fits;
      logic nx_end;
      logic steps_max;
      logic t_lt_av;
      logic merge_av;
      logic need_hdr;
      logic walk_more;
      logic merge_cur;
   } dp_status_type;

endpackage
`default_nettype wire

// ----- hdl/ffa_if.sv -----
`default_nettype none
// Request channel.
interface ffa_req_if;
   logic                        valid;
   logic                        ready;
   logic                        cmd;
   logic [ffa_pkg::BYTE_BITS-1:0] request_bytes;
   logic [ffa_pkg::ADDR_BITS-1:0] block_addr;
   modport source (output valid, cmd, request_bytes, block_addr, input ready);
   modport sink (input valid, cmd, request_bytes, block_addr, output ready);
endinterface

// Result channel.
interface ffa_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ffa_pkg::ADDR_BITS-1:0] data_addr;
   logic                        granted;
   modport source (output valid, data_addr, granted, input ready);
   modport sink (input valid, data_addr, granted, output ready);
endinterface
`default_nettype wire

// ----- hdl/ffa_ram.sv -----
`default_nettype none
// Simple dual-port RAM, one write and one registered read per cycle.
module ffa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// ----- hdl/ffa_datapath.sv -----
`default_nettype none
// Pool memory, walk registers and result register of the allocator.
module ffa_datapath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire ffa_pkg::dp_op_type              op,
   input  wire logic                            req_cmd,
   input  wire logic [ffa_pkg::BYTE_BITS-1:0]   req_request_bytes,
   input  wire logic [ffa_pkg::ADDR_BITS-1:0]   req_block_addr,
   output ffa_pkg::dp_status_type               status,
   output logic [ffa_pkg::ADDR_BITS-1:0]        rsp_data_addr,
   output logic                                 rsp_granted
);
   ffa_pkg::word_type cur_ff, cur_in, prev_ff, prev_in, t_ff, t_in, ff_ff, ff_in;
   ffa_pkg::word_type s_ff, s_in, ps_ff, ps_in, ts_ff, ts_in, steps_ff, steps_in;
   logic [ffa_pkg::NUM_BITS-1:0]  num_ff, num_in;
   logic                          cmd_ff, cmd_in, first_ff, first_in, merged_ff, merged_in;
   logic [ffa_pkg::ADDR_BITS-1:0] clr_ff, clr_in;
   logic                          oob_ff;
   logic [ffa_pkg::ADDR_BITS-1:0] data_addr_ff, data_addr_in;
   logic                          granted_ff, granted_in;

   logic                          mem_we;
   ffa_pkg::word_type             mem_waddr, mem_wdata, mem_raddr, ram_q, rdata;
   ffa_pkg::word_type             num_w, diff, t_link, succ;
   logic [ffa_pkg::BYTE_BITS:0]   bytes_up;

   // Out-of-pool reads give zero, out-of-pool writes are dropped.
   assign rdata = oob_ff ? '0 : ram_q;

   ffa_ram #(
      .WIDTH(ffa_pkg::WORD_BITS),
      .DEPTH(ffa_pkg::POOL_WORDS)
   ) u_ram (
      .clock(clock),
      .we   (mem_we & ~mem_waddr[ffa_pkg::WORD_BITS-1]),
      .waddr(mem_waddr[ffa_pkg::ADDR_BITS-1:0]),
      .wdata(mem_wdata),
      .raddr(mem_raddr[ffa_pkg::ADDR_BITS-1:0]),
      .rdata(ram_q)
   );

   // Derived values shared by several steps.
   assign num_w    = num_ff[ffa_pkg::WORD_BITS-1:0];
   assign diff     = s_ff - num_w;
   assign t_link   = t_ff + rdata;
   assign bytes_up = {1'b0, req_request_bytes} + (ffa_pkg::BYTE_BITS+1)'(3);
   assign succ     = ((s_ff == num_w) || (diff == ffa_pkg::word_type'(1)))
                     ? rdata : cur_ff + num_w + ffa_pkg::word_type'(1);

   // Status for the controller.
   always_comb begin
      status.clear_done = (clr_ff == {ffa_pkg::ADDR_BITS{1'b1}});
      status.is_free    = cmd_ff;
      status.early_fail = (num_ff == '0) || (ff_ff == ffa_pkg::END_MARK);
      status.fits       = ({1'b0, rdata} >= num_ff);
      status.nx_end     = (rdata == ffa_pkg::END_MARK);
      status.steps_max  = (steps_ff == ffa_pkg::END_MARK);
      status.t_lt_av    = (t_ff < ff_ff);
      status.merge_av   = ((t_link + ffa_pkg::word_type'(1)) == ff_ff)
                          && (ff_ff < ffa_pkg::END_MARK);
      status.need_hdr   = (s_ff != num_w) && (diff != ffa_pkg::word_type'(1));
      status.walk_more  = (cur_ff < t_ff) && (steps_ff < ffa_pkg::END_MARK);
      status.merge_cur  = merged_ff && ((t_link + ffa_pkg::word_type'(1)) == cur_ff)
                          && (cur_ff < ffa_pkg::END_MARK);
   end

   // Step execution.
   always_comb begin
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      t_in         = t_ff;
      ff_in        = ff_ff;
      s_in         = s_ff;
      ps_in        = ps_ff;
      ts_in        = ts_ff;
      steps_in     = steps_ff;
      num_in       = num_ff;
      cmd_in       = cmd_ff;
      first_in     = first_ff;
      merged_in    = merged_ff;
      clr_in       = clr_ff;
      data_addr_in = data_addr_ff;
      granted_in   = granted_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      mem_raddr    = '0;
      case (op)
         ffa_pkg::OP_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = {1'b0, clr_ff};
            if (clr_ff == '0) begin
               mem_wdata = ffa_pkg::WORD_BITS'(ffa_pkg::POOL_WORDS - 1);
            end else if (clr_ff == {ffa_pkg::ADDR_BITS{1'b1}}) begin
               mem_wdata = ffa_pkg::END_MARK;
            end
            clr_in = clr_ff + ffa_pkg::ADDR_BITS'(1);
         end
         ffa_pkg::OP_LOAD: begin
            cmd_in   = req_cmd;
            num_in   = bytes_up[ffa_pkg::BYTE_BITS:2];
            t_in     = {1'b0, req_block_addr} + {ffa_pkg::WORD_BITS{1'b1}};
            cur_in   = ff_ff;
            prev_in  = ff_ff;
            first_in = 1'b1;
            steps_in = '0;
         end
         ffa_pkg::OP_RD_CUR: begin
            mem_raddr = cur_ff;
         end
         ffa_pkg::OP_RD_T: begin
            mem_raddr = t_ff;
         end
         ffa_pkg::OP_RD_PREV: begin
            mem_raddr = prev_ff;
         end
         ffa_pkg::OP_ALC_SIZE: begin
            s_in      = rdata;
            mem_raddr = cur_ff + rdata;
            if (!status.fits) begin
               prev_in  = cur_ff;
               ps_in    = rdata;
               first_in = 1'b0;
            end
         end
         ffa_pkg::OP_ALC_NEXT: begin
            cur_in    = rdata;
            steps_in  = steps_ff + ffa_pkg::word_type'(1);
            mem_raddr = rdata;
         end
         ffa_pkg::OP_ALC_FOUND: begin
            if (first_ff) begin
               ff_in = succ;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = prev_ff + ps_ff;
               mem_wdata = succ;
            end
         end
         ffa_pkg::OP_ALC_SPLIT: begin
            if (diff == ffa_pkg::word_type'(1)) begin
               mem_we    = 1'b1;
               mem_waddr = cur_ff;
               mem_wdata = num_w + ffa_pkg::word_type'(1);
            end else if (s_ff != num_w) begin
               mem_we    = 1'b1;
               mem_waddr = cur_ff + num_w + ffa_pkg::word_type'(1);
               mem_wdata = diff - ffa_pkg::word_type'(1);
            end
         end
         ffa_pkg::OP_ALC_HDR: begin
            mem_we    = 1'b1;
            mem_waddr = cur_ff;
            mem_wdata = num_w;
         end
         ffa_pkg::OP_FA_TS: begin
            ts_in = rdata;
            if (status.merge_av) begin
               mem_raddr = ff_ff;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = t_link;
               mem_wdata = ff_ff;
               ff_in     = t_ff;
            end
         end
         ffa_pkg::OP_FA_AS: begin
            mem_we    = 1'b1;
            mem_waddr = t_ff;
            mem_wdata = ts_ff + rdata + ffa_pkg::word_type'(1);
            ff_in     = t_ff;
         end
         ffa_pkg::OP_F_SIZE: begin
            mem_raddr = cur_ff + rdata;
         end
         ffa_pkg::OP_F_NEXT: begin
            prev_in  = cur_ff;
            cur_in   = rdata;
            steps_in = steps_ff + ffa_pkg::word_type'(1);
         end
         ffa_pkg::OP_F_PS: begin
            ps_in     = rdata;
            mem_raddr = t_ff;
         end
         ffa_pkg::OP_F_TS: begin
            mem_we = 1'b1;
            if ((prev_ff + ps_ff + ffa_pkg::word_type'(1)) == t_ff) begin
               merged_in = 1'b1;
               mem_waddr = prev_ff;
               mem_wdata = ps_ff + rdata + ffa_pkg::word_type'(1);
            end else begin
               merged_in = 1'b0;
               mem_waddr = prev_ff + ps_ff;
               mem_wdata = t_ff;
            end
         end
         ffa_pkg::OP_F_RT2: begin
            if (status.merge_cur) begin
               mem_raddr = prev_ff;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = t_link;
               mem_wdata = cur_ff;
            end
         end
         ffa_pkg::OP_F_RP: begin
            ps_in     = rdata;
            mem_raddr = cur_ff;
         end
         ffa_pkg::OP_F_RC: begin
            mem_we    = 1'b1;
            mem_waddr = prev_ff;
            mem_wdata = ps_ff + rdata + ffa_pkg::word_type'(1);
         end
         ffa_pkg::OP_OUT_OK: begin
            granted_in   = 1'b1;
            data_addr_in = cmd_ff ? '0
                           : ffa_pkg::ADDR_BITS'(cur_ff + ffa_pkg::word_type'(1));
         end
         ffa_pkg::OP_OUT_FAIL: begin
            granted_in   = 1'b0;
            data_addr_in = '0;
         end
         default: begin
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         ff_ff  <= '0;
         oob_ff <= 1'b0;
      end else begin
         clr_ff <= clr_in;
         ff_ff  <= ff_in;
         oob_ff <= mem_raddr[ffa_pkg::WORD_BITS-1];
      end
   end

   // Working and result registers.
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      t_ff         <= t_in;
      s_ff         <= s_in;
      ps_ff        <= ps_in;
      ts_ff        <= ts_in;
      steps_ff     <= steps_in;
      num_ff       <= num_in;
      cmd_ff       <= cmd_in;
      first_ff     <= first_in;
      merged_ff    <= merged_in;
      data_addr_ff <= data_addr_in;
      granted_ff   <= granted_in;
   end

   assign rsp_data_addr = data_addr_ff;
   assign rsp_granted   = granted_ff;
endmodule
`default_nettype wire

// ----- hdl/ffa_controller.sv -----
`default_nettype none
// Sequencer for the clearing pass, allocate walk and free relink.
module ffa_controller (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire ffa_pkg::dp_status_type status,
   output ffa_pkg::dp_op_type          op
);
   ffa_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               can_out;

   // The result register may be loaded once the previous result has left.
   assign can_out = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ffa_pkg::S_CLEAR:    if (status.clear_done) state_in = ffa_pkg::S_IDLE;
         ffa_pkg::S_IDLE:     if (req_valid) state_in = ffa_pkg::S_DISPATCH;
         ffa_pkg::S_DISPATCH: begin
            if (!status.is_free) begin
               state_in = status.early_fail ? ffa_pkg::S_FIN_FAIL : ffa_pkg::S_A_RDCUR;
            end else begin
               state_in = status.t_lt_av ? ffa_pkg::S_FA_RT : ffa_pkg::S_F_CHK;
            end
         end
         ffa_pkg::S_A_RDCUR:  state_in = ffa_pkg::S_A_SIZE;
         ffa_pkg::S_A_SIZE:   state_in = status.fits ? ffa_pkg::S_A_FOUND : ffa_pkg::S_A_NEXT;
         ffa_pkg::S_A_NEXT: begin
            state_in = (status.nx_end || status.steps_max) ? ffa_pkg::S_FIN_FAIL
                                                           : ffa_pkg::S_A_SIZE;
         end
         ffa_pkg::S_A_FOUND:  state_in = ffa_pkg::S_A_SPLIT;
         ffa_pkg::S_A_SPLIT:  state_in = status.need_hdr ? ffa_pkg::S_A_HDR : ffa_pkg::S_FIN_OK;
         ffa_pkg::S_A_HDR:    state_in = ffa_pkg::S_FIN_OK;
         ffa_pkg::S_FA_RT:    state_in = ffa_pkg::S_FA_TS;
         ffa_pkg::S_FA_TS:    state_in = status.merge_av ? ffa_pkg::S_FA_AS : ffa_pkg::S_FIN_OK;
         ffa_pkg::S_FA_AS:    state_in = ffa_pkg::S_FIN_OK;
         ffa_pkg::S_F_CHK:    state_in = status.walk_more ? ffa_pkg::S_F_SIZE : ffa_pkg::S_F_PS;
         ffa_pkg::S_F_SIZE:   state_in = ffa_pkg::S_F_NEXT;
         ffa_pkg::S_F_NEXT:   state_in = ffa_pkg::S_F_CHK;
         ffa_pkg::S_F_PS:     state_in = ffa_pkg::S_F_TS;
         ffa_pkg::S_F_TS:     state_in = ffa_pkg::S_F_RT;
         ffa_pkg::S_F_RT:     state_in = ffa_pkg::S_F_RT2;
         ffa_pkg::S_F_RT2:    state_in = status.merge_cur ? ffa_pkg::S_F_RP : ffa_pkg::S_FIN_OK;
         ffa_pkg::S_F_RP:     state_in = ffa_pkg::S_F_RC;
         ffa_pkg::S_F_RC:     state_in = ffa_pkg::S_FIN_OK;
         ffa_pkg::S_FIN_OK:   if (can_out) state_in = ffa_pkg::S_IDLE;
         ffa_pkg::S_FIN_FAIL: if (can_out) state_in = ffa_pkg::S_IDLE;
         default:             state_in = ffa_pkg::S_IDLE;
      endcase
   end

   // Datapath step and handshake outputs.
   always_comb begin
      op           = ffa_pkg::OP_NONE;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ffa_pkg::S_CLEAR:    op = ffa_pkg::OP_CLEAR;
         ffa_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) op = ffa_pkg::OP_LOAD;
         end
         ffa_pkg::S_A_RDCUR:  op = ffa_pkg::OP_RD_CUR;
         ffa_pkg::S_A_SIZE:   op = ffa_pkg::OP_ALC_SIZE;
         ffa_pkg::S_A_NEXT: begin
            if (!status.nx_end && !status.steps_max) op = ffa_pkg::OP_ALC_NEXT;
         end
         ffa_pkg::S_A_FOUND:  op = ffa_pkg::OP_ALC_FOUND;
         ffa_pkg::S_A_SPLIT:  op = ffa_pkg::OP_ALC_SPLIT;
         ffa_pkg::S_A_HDR:    op = ffa_pkg::OP_ALC_HDR;
         ffa_pkg::S_FA_RT:    op = ffa_pkg::OP_RD_T;
         ffa_pkg::S_FA_TS:    op = ffa_pkg::OP_FA_TS;
         ffa_pkg::S_FA_AS:    op = ffa_pkg::OP_FA_AS;
         ffa_pkg::S_F_CHK:    op = status.walk_more ? ffa_pkg::OP_RD_CUR : ffa_pkg::OP_RD_PREV;
         ffa_pkg::S_F_SIZE:   op = ffa_pkg::OP_F_SIZE;
         ffa_pkg::S_F_NEXT:   op = ffa_pkg::OP_F_NEXT;
         ffa_pkg::S_F_PS:     op = ffa_pkg::OP_F_PS;
         ffa_pkg::S_F_TS:     op = ffa_pkg::OP_F_TS;
         ffa_pkg::S_F_RT:     op = ffa_pkg::OP_RD_T;
         ffa_pkg::S_F_RT2:    op = ffa_pkg::OP_F_RT2;
         ffa_pkg::S_F_RP:     op = ffa_pkg::OP_F_RP;
         ffa_pkg::S_F_RC:     op = ffa_pkg::OP_F_RC;
         ffa_pkg::S_FIN_OK: begin
            if (can_out) begin
               op           = ffa_pkg::OP_OUT_OK;
               rsp_valid_in = 1'b1;
            end
         end
         ffa_pkg::S_FIN_FAIL: begin
            if (can_out) begin
               op           = ffa_pkg::OP_OUT_FAIL;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffa_pkg::S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule
`default_nettype wire

// ----- hdl/first_fit_free_list_allocator.sv -----
`default_nettype none
// First-fit allocator over a 1024-word pool kept as an address-ordered free list.
// After reset the block writes the initial pool image (one free block spanning
// the pool) and takes no request until then. One request is worked at a time,
// and the pool memory gives one read or one write a cycle. An allocate steps
// past list nodes reading the size word, then the link word, and adds a header
// write when the block is split. A zero request or an empty list fails before
// any walk. A free that goes in front of the list may merge with the old first
// block. Any other free walks the list and may also merge with the following
// free block. A finished result sits in an output register, so the next request
// is accepted while it waits to be taken. A result that is still waiting when
// the next one is ready holds the block in its final step until the waiting
// result leaves.
module first_fit_free_list_allocator (
   input  wire logic clock,
   input  wire logic reset,
   ffa_req_if.sink   req_ch,
   ffa_rsp_if.source rsp_ch
);
   ffa_pkg::dp_op_type     op;
   ffa_pkg::dp_status_type status;

   ffa_controller u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .rsp_valid(rsp_ch.valid),
      .rsp_ready(rsp_ch.ready),
      .status   (status),
      .op       (op)
   );

   ffa_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .op               (op),
      .req_cmd          (req_ch.cmd),
      .req_request_bytes(req_ch.request_bytes),
      .req_block_addr   (req_ch.block_addr),
      .status           (status),
      .rsp_data_addr    (rsp_ch.data_addr),
      .rsp_granted      (rsp_ch.granted)
   );
endmodule
`default_nettype wire

// ----- hdl/ffa_checker.sv -----
`default_nettype none
// Port-level checks on the allocator.
module ffa_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [ffa_pkg::ADDR_BITS-1:0] rsp_data_addr,
   input wire logic                          rsp_granted
);
   // A stalled result keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_addr) && $stable(rsp_granted))
      else $error("result changed while stalled");

   // A failed allocation reports address zero.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_granted |-> rsp_data_addr == '0)
      else $error("failed allocation with nonzero address");

   // Only one request is worked at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // No result right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind first_fit_free_list_allocator ffa_checker u_ffa_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_data_addr(rsp_ch.data_addr),
   .rsp_granted  (rsp_ch.granted)
);
`default_nettype wire
